/* hw/rtl/assert_macros.svh */
// Assertion helpers, clocked on clk_i, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge.
`define WAVHP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wavhp assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define WAVHP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("wavhp assertion failed");

`endif

/* hw/rtl/wavhp_pkg.sv */
package wavhp_pkg;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StTrunc    = 3'd1,
    StNoRiff   = 3'd2,
    StNoWave   = 3'd3,
    StNoFmt    = 3'd4,
    StFmtSize  = 3'd5,
    StCompress = 3'd6,
    StNoData   = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    status_e     status_code;
    logic [7:0]  channel_count;
    logic [31:0] sample_rate;
    logic [7:0]  bits_per_sample;
    logic [31:0] data_size;
  } out_word_t;

  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWave = "WAVE";
  localparam logic [31:0] TagFmt  = "fmt ";
  localparam logic [31:0] TagData = "data";
  localparam logic [31:0] FmtSize = 32'h10;

endpackage

/* hw/rtl/wavhp_in_stage.sv */
module wavhp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wavhp_pkg::in_word_t in_word_i,
  output logic               vld_o,
  output wavhp_pkg::in_word_t word_o,
  input  logic               take_i
);
  import wavhp_pkg::*;

  logic     vld_q, vld_d;
  in_word_t word_q;

  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;
endmodule

/* hw/rtl/wavhp_parse.sv */
`include "assert_macros.svh"

module wavhp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wavhp_pkg::in_word_t  word_i,
  output logic                res_vld_o,
  output wavhp_pkg::out_word_t res_o
);
  import wavhp_pkg::*;

  localparam logic [4:0] PhIdle    = 5'd0;
  localparam logic [4:0] PhRiff    = 5'd1;
  localparam logic [4:0] PhLen     = 5'd2;
  localparam logic [4:0] PhWave    = 5'd3;
  localparam logic [4:0] PhFmt     = 5'd4;
  localparam logic [4:0] PhFsize   = 5'd5;
  localparam logic [4:0] PhFormat  = 5'd6;
  localparam logic [4:0] PhChan    = 5'd7;
  localparam logic [4:0] PhRate    = 5'd8;
  localparam logic [4:0] PhBrate   = 5'd9;
  localparam logic [4:0] PhAlign   = 5'd10;
  localparam logic [4:0] PhBits    = 5'd11;
  localparam logic [4:0] PhTag2    = 5'd12;
  localparam logic [4:0] PhSksize  = 5'd13;
  localparam logic [4:0] PhSkip    = 5'd14;
  localparam logic [4:0] PhDatatag = 5'd15;
  localparam logic [4:0] PhDsize   = 5'd16;
  localparam logic [4:0] PhDone    = 5'd17;

  function automatic logic [2:0] field_len(input logic [4:0] ph);
    logic [2:0] len;
    unique case (ph)
      PhFormat, PhChan, PhAlign, PhBits: len = 3'd2;
      PhRiff, PhLen, PhWave, PhFmt, PhFsize, PhRate, PhBrate,
      PhTag2, PhSksize, PhDatatag, PhDsize: len = 3'd4;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [31:0] tag_word(input logic [4:0] ph);
    logic [31:0] t;
    unique case (ph)
      PhRiff:             t = TagRiff;
      PhWave:             t = TagWave;
      PhFmt:              t = TagFmt;
      PhTag2, PhDatatag:  t = TagData;
      default:            t = '0;
    endcase
    return t;
  endfunction

  logic [4:0]  phase_q, phase_d;
  logic [1:0]  bif_q, bif_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [7:0]  bits_q, bits_d;
  logic        miss_q, miss_d;

  logic [4:0]  ph;
  logic [1:0]  bif;
  logic [31:0] acc, acc_new, val, tag, skip_dec;
  logic        miss, miss_new, has_tag, field_end;
  logic [7:0]  tag_byte;
  logic [2:0]  len;
  logic        res_vld;
  status_e     st;

  always_comb begin
    ph  = word_i.first_byte ? PhRiff : phase_q;
    bif = word_i.first_byte ? 2'd0   : bif_q;
    acc = word_i.first_byte ? '0     : acc_q;
    miss = word_i.first_byte ? 1'b0  : miss_q;

    phase_d = phase_q;
    bif_d   = bif_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    miss_d  = miss_q;

    if (word_i.first_byte) begin
      phase_d = PhRiff;
      bif_d   = '0;
      acc_d   = '0;
      skip_d  = '0;
      chan_d  = '0;
      rate_d  = '0;
      bits_d  = '0;
      miss_d  = 1'b0;
    end

    acc_new  = {word_i.stream_byte, acc[31:8]};
    tag      = tag_word(ph);
    has_tag  = (ph == PhRiff) || (ph == PhWave) || (ph == PhFmt) ||
               (ph == PhTag2) || (ph == PhDatatag);
    unique case (bif)
      2'd0: tag_byte = tag[31:24];
      2'd1: tag_byte = tag[23:16];
      2'd2: tag_byte = tag[15:8];
      default: tag_byte = tag[7:0];
    endcase
    miss_new  = miss || (has_tag && (tag_byte != word_i.stream_byte));
    len       = field_len(ph);
    field_end = (3'({1'b0, bif}) + 3'd1) >= len;
    val       = (len == 3'd2) ? {16'd0, acc_new[31:16]} : acc_new;
    skip_dec  = skip_q - 32'd1;

    res_vld = 1'b0;
    st      = StOk;

    if ((ph != PhIdle) && (ph < PhDone)) begin
      if (ph == PhSkip) begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PhDatatag;
        end
      end else begin
        acc_d = acc_new;
        if (!field_end) begin
          bif_d  = 2'(bif + 2'd1);
          miss_d = miss_new;
        end else begin
          bif_d   = '0;
          miss_d  = 1'b0;
          phase_d = 5'(ph + 5'd1);
          unique case (ph)
            PhRiff: begin
              res_vld = miss_new;
              st      = StNoRiff;
            end
            PhWave: begin
              res_vld = miss_new;
              st      = StNoWave;
            end
            PhFmt: begin
              res_vld = miss_new;
              st      = StNoFmt;
            end
            PhFsize: begin
              res_vld = (val != FmtSize);
              st      = StFmtSize;
            end
            PhFormat: begin
              res_vld = (val[7:0] != 8'd1);
              st      = StCompress;
            end
            PhChan: chan_d = val[7:0];
            PhRate: rate_d = val;
            PhBits: bits_d = val[7:0];
            PhTag2: phase_d = miss_new ? PhSksize : PhDsize;
            PhSksize: begin
              skip_d  = val;
              phase_d = (val != '0) ? PhSkip : PhDatatag;
            end
            PhDatatag: begin
              res_vld = miss_new;
              st      = StNoData;
            end
            PhDsize: begin
              res_vld = 1'b1;
              st      = StOk;
            end
            default: ;
          endcase
        end
      end
      if (!res_vld && word_i.final_byte) begin
        res_vld = 1'b1;
        st      = StTrunc;
      end
      if (res_vld) begin
        phase_d = PhDone;
      end
    end

    res_o.status_code = st;
    if (st == StOk) begin
      res_o.channel_count   = chan_d;
      res_o.sample_rate     = rate_d;
      res_o.bits_per_sample = bits_d;
      res_o.data_size       = val;
    end else begin
      res_o.channel_count   = '0;
      res_o.sample_rate     = '0;
      res_o.bits_per_sample = '0;
      res_o.data_size       = '0;
    end
    res_vld_o = res_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bif_q   <= '0;
      acc_q   <= '0;
      skip_q  <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      miss_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      miss_q  <= miss_d;
    end
  end

  `WAVHP_ASSERT_NEXT(a_result_ends_parse, step_i && res_vld_o, phase_q == PhDone)
  `WAVHP_ASSERT(a_error_fields_zero, !step_i || !res_vld_o || (res_o.status_code == StOk) ||
                ((res_o.sample_rate == '0) && (res_o.data_size == '0)))
  `WAVHP_ASSERT(a_skip_nonzero, (phase_q != PhSkip) || (skip_q != '0))
  `WAVHP_ASSERT(a_no_field_index, ((phase_q != PhIdle) && (phase_q != PhSkip)) ||
                (bif_q == 2'd0))
endmodule

/* hw/rtl/wavhp_out_stage.sv */
module wavhp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  wavhp_pkg::out_word_t word_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wavhp_pkg::out_word_t out_word_o
);
  import wavhp_pkg::*;

  logic      vld_q, vld_d;
  out_word_t word_q;

  assign space_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;
endmodule

/* hw/rtl/wav_header_parser.sv */
// channel | handshake               | word
// in      | in_valid_i / in_ready_o   | in_word_t: stream_byte, first_byte, final_byte
// out     | out_valid_o / out_ready_i | out_word_t: status, channels, rate, bits, data size
//
// One byte word per cycle unless a held result stalls; the parse step loads each result.
// Input register feeds the parse step, which writes the result register.
// Reset leaves the parser idle until a word with first_byte; no clearing pass.
// A held result stalls the parse step only while out_ready_i is low; the input
// register still takes one more word meanwhile if it is empty.
module wav_header_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wavhp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wavhp_pkg::out_word_t out_word_o
);
  import wavhp_pkg::*;

  logic      stg_vld, space, take, res_vld;
  in_word_t  stg_word;
  out_word_t res_word;

  assign take = stg_vld && space;

  wavhp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .vld_o      (stg_vld),
    .word_o     (stg_word),
    .take_i     (take)
  );

  wavhp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (take),
    .word_i    (stg_word),
    .res_vld_o (res_vld),
    .res_o     (res_word)
  );

  wavhp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_vld),
    .word_i      (res_word),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );
endmodule
